// File: src/lkvc_pkg.sv
package lkvc_pkg;

   localparam int DATA_W      = 32;
   localparam int KEY_W       = 32;
   localparam int OP_W        = 2;
   localparam int OCC_W       = 7;
   localparam int DEF_ENTRIES = 64;

   localparam logic [OP_W-1:0] OP_READ  = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   localparam logic [DATA_W-1:0] CNT_MAX = {DATA_W{1'b1}};

   typedef struct packed {
      logic move;
      logic clear;
   } cell_ctl_type;

endpackage

// File: src/lkvc_cell.sv
module lkvc_cell
   import lkvc_pkg::*;
#(
   parameter int ENTRIES = DEF_ENTRIES,
   parameter int POS     = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cell_ctl_type                 ctl,
   input  logic [$clog2(ENTRIES)-1:0]   limit,
   input  logic                         prev_valid,
   input  logic [KEY_W-1:0]             prev_key,
   input  logic [DATA_W-1:0]            prev_value,
   input  logic [KEY_W-1:0]             cmp_key,
   output logic                         valid,
   output logic [KEY_W-1:0]             key,
   output logic [DATA_W-1:0]            value,
   output logic                         match
);

   localparam int IW = $clog2(ENTRIES);
   localparam logic [IW-1:0] MY_POS = IW'(POS);

   logic              valid_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [DATA_W-1:0] value_ff;
   logic              shift;

   assign shift = ctl.move && (MY_POS <= limit);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.clear) begin
         valid_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         key_ff   <= prev_key;
         value_ff <= prev_value;
      end
   end

   assign valid = valid_ff;
   assign key   = key_ff;
   assign value = value_ff;
   assign match = valid_ff && (key_ff == cmp_key);

endmodule

// File: src/lkvc_match_enc.sv
module lkvc_match_enc
   import lkvc_pkg::*;
#(
   parameter int ENTRIES = DEF_ENTRIES
) (
   input  logic [ENTRIES-1:0]              match,
   input  logic [ENTRIES-1:0][DATA_W-1:0]  values,
   output logic                            hit,
   output logic [$clog2(ENTRIES)-1:0]      pos,
   output logic [DATA_W-1:0]               value
);

   localparam int IW = $clog2(ENTRIES);

   // at most one cell matches, so plain OR trees suffice
   always_comb begin
      pos   = '0;
      value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (match[i]) begin
            pos   = pos | IW'(i);
            value = value | values[i];
         end
      end
      hit = |match;
   end

endmodule

// File: src/lru_key_value_cache.sv
// A request is captured with its compare result; its result beat is registered in
// the commit phase. No new item is taken until the current one commits: the idle
// phase compares the key in every cell, the commit phase updates the recency chain
// and loads the result register. A stalled result holds the next item in commit,
// with req_stall high. Synchronous reset empties the table and zeroes the counters.
module lru_key_value_cache
   import lkvc_pkg::*;
#(
   parameter int ENTRIES = DEF_ENTRIES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [OP_W-1:0]   req_opcode,
   input  logic [KEY_W-1:0]  req_lookup_key,
   input  logic [DATA_W-1:0] req_write_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_hit,
   output logic [DATA_W-1:0] rsp_read_value,
   output logic [OCC_W-1:0]  rsp_occupancy,
   output logic [DATA_W-1:0] rsp_hit_total,
   output logic [DATA_W-1:0] rsp_miss_total
);

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);
   localparam logic [IW-1:0] LAST_POS   = IW'(ENTRIES - 1);

   typedef enum logic {PH_IDLE, PH_COMMIT} phase_type;

   phase_type         phase_ff;
   logic [OP_W-1:0]   op_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [DATA_W-1:0] wval_ff;
   logic              found_ff;
   logic [IW-1:0]     pos_ff;
   logic [DATA_W-1:0] hval_ff;
   logic              rsp_valid_ff;
   logic              rsp_hit_ff;
   logic [DATA_W-1:0] rsp_value_ff;
   logic [CW-1:0]     used_ff;
   logic [DATA_W-1:0] hits_ff;
   logic [DATA_W-1:0] misses_ff;

   logic [CW-1:0]     used_in;
   logic [DATA_W-1:0] hits_in;
   logic [DATA_W-1:0] misses_in;

   logic                             fire;
   cell_ctl_type                     ctl;
   logic [IW-1:0]                    limit;
   logic [DATA_W-1:0]                head_value;
   logic [ENTRIES-1:0]               chain_valid;
   logic [ENTRIES-1:0][KEY_W-1:0]    chain_key;
   logic [ENTRIES-1:0][DATA_W-1:0]   chain_value;
   logic [ENTRIES-1:0]               match;
   logic                             enc_hit;
   logic [IW-1:0]                    enc_pos;
   logic [DATA_W-1:0]                enc_value;

   assign req_stall = (phase_ff != PH_IDLE);
   assign fire = (phase_ff == PH_COMMIT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      ctl.clear  = fire && (op_ff == OP_CLEAR);
      ctl.move   = fire && (((op_ff == OP_READ) && found_ff) || (op_ff == OP_WRITE));
      limit      = found_ff ? pos_ff : LAST_POS;
      head_value = (op_ff == OP_WRITE) ? wval_ff : hval_ff;
   end

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      logic              p_valid;
      logic [KEY_W-1:0]  p_key;
      logic [DATA_W-1:0] p_value;

      if (i == 0) begin : g_head
         assign p_valid = 1'b1;
         assign p_key   = key_ff;
         assign p_value = head_value;
      end else begin : g_link
         assign p_valid = chain_valid[i-1];
         assign p_key   = chain_key[i-1];
         assign p_value = chain_value[i-1];
      end

      lkvc_cell #(
         .ENTRIES (ENTRIES),
         .POS     (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .limit      (limit),
         .prev_valid (p_valid),
         .prev_key   (p_key),
         .prev_value (p_value),
         .cmp_key    (req_lookup_key),
         .valid      (chain_valid[i]),
         .key        (chain_key[i]),
         .value      (chain_value[i]),
         .match      (match[i])
      );
   end

   lkvc_match_enc #(
      .ENTRIES (ENTRIES)
   ) u_enc (
      .match  (match),
      .values (chain_value),
      .hit    (enc_hit),
      .pos    (enc_pos),
      .value  (enc_value)
   );

   always_comb begin
      used_in   = used_ff;
      hits_in   = hits_ff;
      misses_in = misses_ff;
      case (op_ff)
         OP_READ: begin
            if (found_ff) begin
               hits_in = (hits_ff == CNT_MAX) ? hits_ff : hits_ff + 1'b1;
            end else begin
               misses_in = (misses_ff == CNT_MAX) ? misses_ff : misses_ff + 1'b1;
            end
         end
         OP_WRITE: begin
            if (!found_ff && (used_ff != FULL_COUNT)) begin
               used_in = used_ff + 1'b1;
            end
         end
         OP_CLEAR: begin
            used_in   = '0;
            hits_in   = '0;
            misses_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
         used_ff      <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (phase_ff)
            PH_IDLE: begin
               if (req_valid) begin
                  op_ff    <= req_opcode;
                  key_ff   <= req_lookup_key;
                  wval_ff  <= req_write_value;
                  found_ff <= enc_hit;
                  pos_ff   <= enc_pos;
                  hval_ff  <= enc_value;
                  phase_ff <= PH_COMMIT;
               end
            end
            PH_COMMIT: begin
               if (fire) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_hit_ff   <= (op_ff == OP_READ) && found_ff;
                  rsp_value_ff <= ((op_ff == OP_READ) && found_ff) ? hval_ff : '0;
                  used_ff      <= used_in;
                  hits_ff      <= hits_in;
                  misses_ff    <= misses_in;
                  phase_ff     <= PH_IDLE;
               end
            end
            default: begin
               phase_ff <= PH_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_occupancy  = OCC_W'(used_ff);
   assign rsp_hit_total  = hits_ff;
   assign rsp_miss_total = misses_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= FULL_COUNT)
      else $error("occupancy above table size");

   a_valid_count: assert property (@(posedge clock) disable iff (reset)
      $countones(chain_valid) == int'(used_ff))
      else $error("valid cells disagree with occupancy");

   a_unique_match: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> $onehot0(match))
      else $error("key matched in more than one cell");

   a_hit_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> (rsp_hit_total != '0))
      else $error("hit beat without hit count");

   a_write_fills: assert property (@(posedge clock) disable iff (reset)
      (fire && (op_ff == OP_WRITE)) |=> (used_ff != '0))
      else $error("table empty after write");

endmodule
